### hdl/fpnr_pkg.sv
// Package: shared constants, sequencer states and multiplier control for the n-th root block.
package fpnr_pkg;

   // Width of one limb handled by the shared multiplier.
   localparam int LIMB_W = 32;

   // Width of the degree field on the request channel.
   localparam int DEGREE_W = 4;

   // Defaults for the top-level parameters.
   localparam int MAX_DEGREE_DEF = 8;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int DATA_WIDTH_DEF = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BIT_START,
      ST_CMP,
      ST_MUL,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear;   // zero the accumulator
      logic issue;   // start one limb-by-limb partial product
   } mac_ctrl_type;

endpackage

### hdl/fpnr_mac.sv
// Shared limb multiplier with a registered product and a wide accumulator.
module fpnr_mac
   import fpnr_pkg::*;
#(
   parameter int ACC_W = 2 * LIMB_W,
   parameter int POS_W = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  mac_ctrl_type       mac_ctrl,
   input  logic [LIMB_W-1:0]  op_a,
   input  logic [LIMB_W-1:0]  op_b,
   input  logic [POS_W-1:0]   limb_pos,
   output logic [ACC_W-1:0]   acc_sum
);

   logic [2*LIMB_W-1:0] prod_ff;
   logic [2*LIMB_W-1:0] prod_in;
   logic [POS_W-1:0]    pos_ff;
   logic [POS_W-1:0]    pos_in;
   logic                pv_ff;
   logic                pv_in;
   logic [ACC_W-1:0]    acc_ff;
   logic [ACC_W-1:0]    acc_in;
   logic [ACC_W-1:0]    addend;

   // Align the registered partial product to its limb position.
   assign addend  = pv_ff ? (ACC_W'(prod_ff) << (LIMB_W * int'(pos_ff))) : '0;
   assign acc_sum = acc_ff + addend;

   always_comb begin
      prod_in = mac_ctrl.issue ? (2*LIMB_W)'(op_a) * (2*LIMB_W)'(op_b) : prod_ff;
      pos_in  = mac_ctrl.issue ? limb_pos : pos_ff;
      pv_in   = mac_ctrl.issue;
      acc_in  = mac_ctrl.clear ? '0 : acc_sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= pv_in;
      end
      prod_ff <= prod_in;
      pos_ff  <= pos_in;
      acc_ff  <= acc_in;
   end

endmodule

### hdl/fixed_point_nth_root.sv
// Top level: signed fixed-point n-th root by bitwise search with a shared limb multiplier.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_value, req_degree
//   rsp      out        rsp_valid/rsp_stall   rsp_root_value, rsp_domain_error
//
// Degree 0, degree 1 and even-degree negative items go straight to the done
// state. Otherwise each of the DATA_WIDTH-1 result bits runs a start step,
// then compares and multiplies the power until it passes the bound or reaches
// the degree (at most degree-1 multiplies); a multiply issues one partial
// product per pair of bound and candidate limbs (NPL and NCL are the limb
// counts of the bound and the candidate), then drains.
// All multiplies share the single 32x32 limb multiplier.
// Reset clears the sequencer and the response valid; no clearing pass.
// req_stall is high whenever an item is in work; a finished item waits in
// the done state while the response register is held by rsp_stall.
module fixed_point_nth_root
   import fpnr_pkg::*;
#(
   parameter int MAX_DEGREE = MAX_DEGREE_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   input  logic        [DEGREE_W-1:0]   req_degree,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_root_value,
   output logic                         rsp_domain_error
);

   // Bound = |x| << FRAC_BITS*(degree-1); the candidate has one bit less than x.
   localparam int BOUND_W = DATA_WIDTH + FRAC_BITS * (MAX_DEGREE - 1);
   localparam int CAND_W  = DATA_WIDTH - 1;
   localparam int NPL     = (BOUND_W + LIMB_W - 1) / LIMB_W;
   localparam int NCL     = (CAND_W + LIMB_W - 1) / LIMB_W;
   localparam int ACC_W   = (NPL + NCL) * LIMB_W;
   localparam int PI_W    = (NPL > 1) ? $clog2(NPL) : 1;
   localparam int CJ_W    = (NCL > 1) ? $clog2(NCL) : 1;
   localparam int POS_W   = (NPL + NCL - 1 > 1) ? $clog2(NPL + NCL - 1) : 1;
   localparam int BIT_W   = (CAND_W > 1) ? $clog2(CAND_W) : 1;
   localparam int DEGC_W  = $clog2(MAX_DEGREE + 1);

   state_type              state_ff, state_in;
   logic                   neg_ff, neg_in;
   logic [DEGC_W-1:0]      deg_ff, deg_in;
   logic [DEGC_W-1:0]      k_ff, k_in;
   logic [BOUND_W-1:0]     bound_ff, bound_in;
   logic [CAND_W-1:0]      y_ff, y_in;
   logic [CAND_W-1:0]      cand_ff, cand_in;
   logic [BIT_W-1:0]       bit_ff, bit_in;
   logic [ACC_W-1:0]       p_ff, p_in;
   logic [PI_W-1:0]        i_ff, i_in;
   logic [CJ_W-1:0]        j_ff, j_in;
   logic [DATA_WIDTH-1:0]  res_ff, res_in;
   logic                   res_err_ff, res_err_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]  rsp_root_ff, rsp_root_in;
   logic                   rsp_err_ff, rsp_err_in;

   mac_ctrl_type           mac_ctrl;
   logic [POS_W-1:0]       limb_pos;
   logic [LIMB_W-1:0]      op_a;
   logic [LIMB_W-1:0]      op_b;
   logic [ACC_W-1:0]       mac_sum;
   logic [NCL*LIMB_W-1:0]  cand_pad;

   logic [DATA_WIDTH-1:0]  raw;
   logic [DATA_WIDTH-1:0]  mag;
   logic                   req_neg;
   logic [DEGC_W-1:0]      deg_sat;
   logic                   over;
   logic [CAND_W-1:0]      y_next;
   logic                   out_free;

   assign raw      = req_value;
   assign req_neg  = raw[DATA_WIDTH-1];
   assign mag      = req_neg ? (~raw + 1'b1) : raw;
   assign deg_sat  = (int'(req_degree) > MAX_DEGREE) ? DEGC_W'(MAX_DEGREE)
                                                     : DEGC_W'(req_degree);
   assign over     = p_ff > ACC_W'(bound_ff);
   assign y_next   = over ? y_ff : cand_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Operand selection for the shared multiplier.
   assign cand_pad = (NCL*LIMB_W)'(cand_ff);
   assign op_a     = p_ff[i_ff*LIMB_W +: LIMB_W];
   assign op_b     = cand_pad[j_ff*LIMB_W +: LIMB_W];
   assign limb_pos = POS_W'(i_ff) + POS_W'(j_ff);

   fpnr_mac #(
      .ACC_W (ACC_W),
      .POS_W (POS_W)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .mac_ctrl (mac_ctrl),
      .op_a     (op_a),
      .op_b     (op_b),
      .limb_pos (limb_pos),
      .acc_sum  (mac_sum)
   );

   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      deg_in       = deg_ff;
      k_in         = k_ff;
      bound_in     = bound_ff;
      y_in         = y_ff;
      cand_in      = cand_ff;
      bit_in       = bit_ff;
      p_in         = p_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      res_in       = res_ff;
      res_err_in   = res_err_ff;
      mac_ctrl     = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_root_in  = rsp_root_ff;
      rsp_err_in   = rsp_err_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               neg_in = req_neg;
               deg_in = deg_sat;
               if (deg_sat == '0 || (req_neg && !deg_sat[0])) begin
                  // Degree zero, or even root of a negative value.
                  res_in     = '0;
                  res_err_in = 1'b1;
                  state_in   = ST_DONE;
               end else if (deg_sat == DEGC_W'(1)) begin
                  // First root: pass the value through untouched.
                  res_in     = raw;
                  res_err_in = 1'b0;
                  state_in   = ST_DONE;
               end else begin
                  bound_in = BOUND_W'(mag) << (FRAC_BITS * (int'(deg_sat) - 1));
                  y_in     = '0;
                  bit_in   = BIT_W'(CAND_W - 1);
                  state_in = ST_BIT_START;
               end
            end
         end
         ST_BIT_START: begin
            // Set the trial bit; the first power is the candidate itself.
            cand_in  = y_ff | (CAND_W'(1) << bit_ff);
            p_in     = ACC_W'(y_ff | (CAND_W'(1) << bit_ff));
            k_in     = DEGC_W'(1);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (over || k_ff == deg_ff) begin
               // Drop the bit on overflow, keep it once the full power fits.
               y_in = y_next;
               if (bit_ff == '0) begin
                  res_in     = neg_ff ? (~DATA_WIDTH'(y_next) + 1'b1) : DATA_WIDTH'(y_next);
                  res_err_in = 1'b0;
                  state_in   = ST_DONE;
               end else begin
                  bit_in   = bit_ff - 1'b1;
                  state_in = ST_BIT_START;
               end
            end else begin
               mac_ctrl.clear = 1'b1;
               i_in           = '0;
               j_in           = '0;
               state_in       = ST_MUL;
            end
         end
         ST_MUL: begin
            // One partial product per cycle, candidate limbs innermost.
            mac_ctrl.issue = 1'b1;
            if (j_ff == CJ_W'(NCL - 1)) begin
               j_in = '0;
               if (i_ff == PI_W'(NPL - 1)) begin
                  state_in = ST_DRAIN;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            // Fold in the last partial product and advance the power.
            p_in     = mac_sum;
            k_in     = k_ff + 1'b1;
            state_in = ST_CMP;
         end
         ST_DONE: begin
            // Hold the result until the response register is free.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_root_in  = res_ff;
               rsp_err_in   = res_err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff      <= neg_in;
      deg_ff      <= deg_in;
      k_ff        <= k_in;
      bound_ff    <= bound_in;
      y_ff        <= y_in;
      cand_ff     <= cand_in;
      bit_ff      <= bit_in;
      p_ff        <= p_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      res_ff      <= res_in;
      res_err_ff  <= res_err_in;
      rsp_root_ff <= rsp_root_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_root_value   = rsp_root_ff;
   assign rsp_domain_error = rsp_err_ff;

endmodule
